### src/bb3_pkg.sv
// Shared types, constants and helper functions of the 3x3 RGB box blur.
package bb3_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;

   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int ROW_W     = $clog2(MAX_HEIGHT);
   localparam int DIM_W     = 11;
   localparam int IDX_W     = 4;
   localparam int CHAN_W    = 8;
   localparam int PIX_W     = 3 * CHAN_W;
   localparam int LINE_W    = 2 * PIX_W;
   localparam int OUT_POS_W = 10;
   localparam int NUM_CHAN  = 3;
   localparam int CHAN_SEL_W = $clog2(NUM_CHAN);

   // 3x3 sums of 8-bit values stay below 2^12
   localparam int SUM_W       = 12;
   localparam int CNT_W       = 4;
   localparam int NUM_W       = SUM_W + 1;
   localparam int RECIP_W     = 17;
   localparam int RECIP_SHIFT = 17;
   localparam int PROD_W      = NUM_W + RECIP_W;

   localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = IDX_W'(0);
   localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = IDX_W'(1);

   localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
   localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);
   localparam logic [DIM_W-1:0] MAX_W_DIM    = DIM_W'(MAX_WIDTH);
   localparam logic [DIM_W-1:0] MAX_H_DIM    = DIM_W'(MAX_HEIGHT);

   localparam logic [CHAN_SEL_W-1:0] CHAN_LAST = CHAN_SEL_W'(NUM_CHAN - 1);

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } pixel_type;

   // controller -> datapath
   typedef struct packed {
      logic                  start;
      logic                  advance;
      logic                  sum;
      logic                  div;
      logic [CHAN_SEL_W-1:0] chan;
      logic                  load_out;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic drop;
      logic started;
      logic out_free;
   } status_type;

   // ceil(2^17 / (2*count)); exact floor for numerators below 2^15
   function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
      logic [RECIP_W-1:0] r;
      unique case (cnt)
         CNT_W'(1): r = RECIP_W'(65536);
         CNT_W'(2): r = RECIP_W'(32768);
         CNT_W'(3): r = RECIP_W'(21846);
         CNT_W'(4): r = RECIP_W'(16384);
         CNT_W'(6): r = RECIP_W'(10923);
         CNT_W'(9): r = RECIP_W'(7282);
         default:   r = '0;
      endcase
      return r;
   endfunction

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] lim);
      logic [DIM_W-1:0] r;
      if (v == '0) r = DIM_W'(1);
      else if (v > lim) r = lim;
      else r = v;
      return r;
   endfunction

endpackage

### src/bb3_channels.sv
// Handshake channel interfaces: pixel input, blurred result, register write.
interface bb3_req_if;
   import bb3_pkg::*;
   logic              valid;
   logic              ready;
   logic              action;
   logic [CHAN_W-1:0] red_in;
   logic [CHAN_W-1:0] green_in;
   logic [CHAN_W-1:0] blue_in;
   modport source (output valid, action, red_in, green_in, blue_in, input ready);
   modport sink   (input valid, action, red_in, green_in, blue_in, output ready);
endinterface

interface bb3_rsp_if;
   import bb3_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CHAN_W-1:0]    red_out;
   logic [CHAN_W-1:0]    green_out;
   logic [CHAN_W-1:0]    blue_out;
   logic [OUT_POS_W-1:0] out_row;
   logic [OUT_POS_W-1:0] out_col;
   logic                 frame_last;
   modport source (output valid, red_out, green_out, blue_out, out_row, out_col, frame_last,
                   input ready);
   modport sink   (input valid, red_out, green_out, blue_out, out_row, out_col, frame_last,
                   output ready);
endinterface

interface bb3_csr_if;
   import bb3_pkg::*;
   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] index;
   logic [DIM_W-1:0] wdata;
   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

### src/bb3_datapath.sv
// Blur datapath: line store, 3x3 window, position counters, sums, divider, result register.
module bb3_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_action,
   input  bb3_pkg::pixel_type            in_pixel,
   input  logic                          csr_we,
   input  logic [bb3_pkg::IDX_W-1:0]     csr_index,
   input  logic [bb3_pkg::DIM_W-1:0]     csr_data,
   input  bb3_pkg::cmd_type              cmd,
   output bb3_pkg::status_type           status,
   input  logic                          rsp_take,
   output logic                          rsp_valid,
   output logic [bb3_pkg::CHAN_W-1:0]    rsp_red,
   output logic [bb3_pkg::CHAN_W-1:0]    rsp_green,
   output logic [bb3_pkg::CHAN_W-1:0]    rsp_blue,
   output logic [bb3_pkg::OUT_POS_W-1:0] rsp_row,
   output logic [bb3_pkg::OUT_POS_W-1:0] rsp_col,
   output logic                          rsp_last
);
   import bb3_pkg::*;

   logic [LINE_W-1:0] line_mem [MAX_WIDTH];
   logic [LINE_W-1:0] line_rd_ff;

   pixel_type         pix_ff;
   pixel_type         win_ff [9];

   logic [DIM_W-1:0]  width_ff, width_in;
   logic [DIM_W-1:0]  height_ff, height_in;
   logic [DIM_W-1:0]  in_row_ff, in_row_in;
   logic [COL_W-1:0]  in_col_ff, in_col_in;
   logic [ROW_W-1:0]  emit_row_ff, emit_row_in;
   logic [COL_W-1:0]  emit_col_ff, emit_col_in;

   logic [SUM_W-1:0]  sum_ff [NUM_CHAN];
   logic [CNT_W-1:0]  cnt_ff;
   logic              last_ff;
   logic [CHAN_W-1:0] mean_ff [NUM_CHAN];

   logic                 out_valid_ff;
   logic [CHAN_W-1:0]    out_red_ff, out_green_ff, out_blue_ff;
   logic [OUT_POS_W-1:0] out_row_ff, out_col_ff;
   logic                 out_last_ff;

   logic              frame_in;
   logic [COL_W-1:0]  col_eff;
   logic              col_wrap;
   logic [2:0]        row_ok, col_ok;
   logic [1:0]        nr, nc;
   logic [CNT_W-1:0]  cnt;
   logic [SUM_W-1:0]  sum_red, sum_green, sum_blue;
   logic [NUM_W-1:0]  num;
   logic [PROD_W-1:0] prod;
   logic              cfg_hit;

   // item position and window decisions
   always_comb begin
      frame_in       = in_row_ff < height_ff;
      col_eff        = (DIM_W'(in_col_ff) >= width_ff) ? '0 : in_col_ff;
      col_wrap       = (DIM_W'(col_eff) + DIM_W'(1)) >= width_ff;
      status.drop    = in_action && frame_in;
      status.started = (in_row_ff >= DIM_W'(2)) ||
                       ((in_row_ff == DIM_W'(1)) && (col_eff != '0));
      status.out_free = !out_valid_ff || rsp_take;
   end

   // in-frame mask of the 3x3 neighborhood around the emit position
   always_comb begin
      row_ok[0] = emit_row_ff != '0;
      row_ok[1] = 1'b1;
      row_ok[2] = (DIM_W'(emit_row_ff) + DIM_W'(1)) < height_ff;
      col_ok[0] = emit_col_ff != '0;
      col_ok[1] = 1'b1;
      col_ok[2] = (DIM_W'(emit_col_ff) + DIM_W'(1)) < width_ff;
      nr  = 2'(row_ok[0]) + 2'(row_ok[2]) + 2'd1;
      nc  = 2'(col_ok[0]) + 2'(col_ok[2]) + 2'd1;
      cnt = CNT_W'(nr) * CNT_W'(nc);
      sum_red   = '0;
      sum_green = '0;
      sum_blue  = '0;
      for (int dr = 0; dr < 3; dr++) begin
         for (int dc = 0; dc < 3; dc++) begin
            if (row_ok[dr] && col_ok[dc]) begin
               sum_red   = sum_red   + SUM_W'(win_ff[dr*3 + dc].red);
               sum_green = sum_green + SUM_W'(win_ff[dr*3 + dc].green);
               sum_blue  = sum_blue  + SUM_W'(win_ff[dr*3 + dc].blue);
            end
         end
      end
   end

   // rounded mean: floor((2*sum + n) / (2*n)) by reciprocal multiply
   always_comb begin
      num  = (NUM_W'(sum_ff[cmd.chan]) << 1) + NUM_W'(cnt_ff);
      prod = PROD_W'(num) * PROD_W'(recip(cnt_ff));
   end

   // frame geometry and position counters
   always_comb begin
      width_in    = width_ff;
      height_in   = height_ff;
      in_row_in   = in_row_ff;
      in_col_in   = in_col_ff;
      emit_row_in = emit_row_ff;
      emit_col_in = emit_col_ff;
      cfg_hit     = csr_we && ((csr_index == REG_FRAME_WIDTH) ||
                               (csr_index == REG_FRAME_HEIGHT));
      if (cfg_hit) begin
         if (csr_index == REG_FRAME_WIDTH) width_in = clamp_dim(csr_data, MAX_W_DIM);
         else height_in = clamp_dim(csr_data, MAX_H_DIM);
         in_row_in   = '0;
         in_col_in   = '0;
         emit_row_in = '0;
         emit_col_in = '0;
      end else if (cmd.advance) begin
         if (col_wrap) begin
            in_col_in = '0;
            in_row_in = in_row_ff + DIM_W'(1);
         end else begin
            in_col_in = col_eff + COL_W'(1);
         end
      end else if (cmd.load_out) begin
         if (last_ff) begin
            in_row_in   = '0;
            in_col_in   = '0;
            emit_row_in = '0;
            emit_col_in = '0;
         end else if (!col_ok[2]) begin
            emit_col_in = '0;
            emit_row_in = emit_row_ff + ROW_W'(1);
         end else begin
            emit_col_in = emit_col_ff + COL_W'(1);
         end
      end
   end

   // line store: each entry holds the pixel two rows up and the one a row up
   always_ff @(posedge clock) begin
      if (cmd.start) line_rd_ff <= line_mem[col_eff];
      if (cmd.advance) line_mem[col_eff] <= {line_rd_ff[PIX_W-1:0], pix_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
         in_row_ff    <= '0;
         in_col_ff    <= '0;
         emit_row_ff  <= '0;
         emit_col_ff  <= '0;
         out_valid_ff <= 1'b0;
         for (int k = 0; k < 9; k++) win_ff[k] <= '0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         in_row_ff   <= in_row_in;
         in_col_ff   <= in_col_in;
         emit_row_ff <= emit_row_in;
         emit_col_ff <= emit_col_in;
         if (cmd.load_out) out_valid_ff <= 1'b1;
         else if (rsp_take) out_valid_ff <= 1'b0;
         if (cmd.advance) begin
            for (int dr = 0; dr < 3; dr++) begin
               win_ff[dr*3]     <= win_ff[dr*3 + 1];
               win_ff[dr*3 + 1] <= win_ff[dr*3 + 2];
            end
            win_ff[2] <= line_rd_ff[LINE_W-1:PIX_W];
            win_ff[5] <= line_rd_ff[PIX_W-1:0];
            win_ff[8] <= pix_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) pix_ff <= frame_in ? in_pixel : '0;
      if (cmd.sum) begin
         sum_ff[0] <= sum_red;
         sum_ff[1] <= sum_green;
         sum_ff[2] <= sum_blue;
         cnt_ff    <= cnt;
         last_ff   <= !row_ok[2] && !col_ok[2];
      end
      if (cmd.div) mean_ff[cmd.chan] <= prod[RECIP_SHIFT +: CHAN_W];
      if (cmd.load_out) begin
         out_red_ff   <= mean_ff[0];
         out_green_ff <= mean_ff[1];
         out_blue_ff  <= mean_ff[2];
         out_row_ff   <= OUT_POS_W'(emit_row_ff);
         out_col_ff   <= OUT_POS_W'(emit_col_ff);
         out_last_ff  <= last_ff;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_red   = out_red_ff;
   assign rsp_green = out_green_ff;
   assign rsp_blue  = out_blue_ff;
   assign rsp_row   = out_row_ff;
   assign rsp_col   = out_col_ff;
   assign rsp_last  = out_last_ff;

endmodule

### src/bb3_control.sv
// Sequencing state machine for one item: read, window shift, sum, divide, emit.
module bb3_control (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  bb3_pkg::status_type status,
   output bb3_pkg::cmd_type    cmd
);
   import bb3_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_WINDOW = 5'b00010,
      ST_SUM    = 5'b00100,
      ST_DIV    = 5'b01000,
      ST_EMIT   = 5'b10000
   } state_type;

   state_type             state_ff, state_in;
   logic [CHAN_SEL_W-1:0] chan_ff, chan_in;

   always_comb begin
      state_in  = state_ff;
      chan_in   = chan_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.chan  = chan_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            // a drain beat inside the frame is taken and dropped
            if (req_valid && !status.drop) begin
               cmd.start = 1'b1;
               state_in  = ST_WINDOW;
            end
         end
         ST_WINDOW: begin
            cmd.advance = 1'b1;
            state_in    = status.started ? ST_SUM : ST_IDLE;
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            chan_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div = 1'b1;
            if (chan_ff == CHAN_LAST) state_in = ST_EMIT;
            else chan_in = chan_ff + CHAN_SEL_W'(1);
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         chan_ff  <= '0;
      end else begin
         state_ff <= state_in;
         chan_ff  <= chan_in;
      end
   end

endmodule

### src/box_blur_3x3_rgb.sv
// Top level of the streaming 3x3 RGB box blur.
// Streaming 3x3 box blur over one RGB frame given in raster order. Each
// req beat is a pixel (action 0) or a drain step (action 1); each rsp beat
// is the rounded-half-up mean of the in-frame 3x3 neighborhood of one pixel
// (9 pixels inside, 6 on an edge, 4 in a corner) with its row, column and a
// frame_last flag on the final pixel. A result trails its input by one row
// plus one pixel, so after the last pixel the user sends drain beats (or
// further pixels, which are then treated as drains) until frame_last shows;
// the next beat starts a new frame. A drain sent while the frame is still
// being filled is taken and discarded. A beat that is dropped is only taken,
// a beat that yields no result passes the line store read and window shift,
// and one that yields a result goes on through the 3x3 sum, then one shared
// reciprocal multiplier used once per color channel, then the result load;
// the result load also waits until the previous result has been taken. The
// finished result sits in an output register, so the next req beat is taken
// while rsp waits. The line store is one 1024 x 48 single-port-write memory
// with no clear; entries are always written before any in-frame read. The
// csr port takes frame_width (index 0) and frame_height (index 1), each
// clamped to 1..1024; any such write restarts the frame. Write registers
// only while the block is idle.
module box_blur_3x3_rgb (
   input  logic      clock,
   input  logic      reset,
   bb3_req_if.sink   req_bus,
   bb3_rsp_if.source rsp_bus,
   bb3_csr_if.sink   csr_bus
);
   import bb3_pkg::*;

   cmd_type    cmd;
   status_type status;
   pixel_type  in_pixel;

   // pack the three channels as red, green, blue from the top bit down
   assign in_pixel = '{red: req_bus.red_in, green: req_bus.green_in, blue: req_bus.blue_in};

   // register writes never stall
   assign csr_bus.ready = 1'b1;

   bb3_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   bb3_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .in_action (req_bus.action),
      .in_pixel  (in_pixel),
      .csr_we    (csr_bus.valid),
      .csr_index (csr_bus.index),
      .csr_data  (csr_bus.wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_take  (rsp_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_red   (rsp_bus.red_out),
      .rsp_green (rsp_bus.green_out),
      .rsp_blue  (rsp_bus.blue_out),
      .rsp_row   (rsp_bus.out_row),
      .rsp_col   (rsp_bus.out_col),
      .rsp_last  (rsp_bus.frame_last)
   );

endmodule

### src/bb3_checker.sv
// Port-level assertions for the box blur and the bind that attaches them.
module bb3_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          req_action,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [bb3_pkg::CHAN_W-1:0]    rsp_red,
   input logic [bb3_pkg::CHAN_W-1:0]    rsp_green,
   input logic [bb3_pkg::CHAN_W-1:0]    rsp_blue,
   input logic [bb3_pkg::OUT_POS_W-1:0] rsp_row,
   input logic [bb3_pkg::OUT_POS_W-1:0] rsp_col,
   input logic                          rsp_last
);
   import bb3_pkg::*;

   logic req_beat;
   assign req_beat = req_valid && req_ready;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_red) && $stable(rsp_green) &&
      $stable(rsp_blue) && $stable(rsp_row) && $stable(rsp_col) && $stable(rsp_last))
      else $error("rsp payload changed while stalled");

   // reset empties the result register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   // a pixel beat is always processed, so the next cycle cannot take another
   a_pixel_busy: assert property (@(posedge clock) disable iff (reset)
      req_beat && !req_action |=> !req_ready)
      else $error("req ready right after a pixel beat");

   // a result is never loaded in the same cycle as a req beat or as its window shift
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_beat, 1) && !$past(req_beat, 2))
      else $error("rsp appeared too soon after a req beat");

endmodule

bind box_blur_3x3_rgb bb3_checker u_bb3_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_bus.valid),
   .req_ready  (req_bus.ready),
   .req_action (req_bus.action),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .rsp_red    (rsp_bus.red_out),
   .rsp_green  (rsp_bus.green_out),
   .rsp_blue   (rsp_bus.blue_out),
   .rsp_row    (rsp_bus.out_row),
   .rsp_col    (rsp_bus.out_col),
   .rsp_last   (rsp_bus.frame_last)
);

### tb/bb3_tb_pkg.sv
`timescale 1ns / 1ps
// Beat action codes shared by the blur stimulus and the blur checker.
package bb3_tb_pkg;

   localparam logic ACT_PIXEL = 1'b0;
   localparam logic ACT_DRAIN = 1'b1;

endpackage

### tb/bb3_blur_checker.sv
`timescale 1ns / 1ps
// Checker for the 3x3 RGB box blur: predicts each blurred pixel and compares rsp beats.
module bb3_blur_checker (
   input  logic clock,
   input  logic reset,
   bb3_req_if   req,
   bb3_rsp_if   rsp,
   bb3_csr_if   csr,
   output int   fail_count,
   output int   pending
);
   import bb3_pkg::*;
   import bb3_tb_pkg::*;

   typedef struct packed {
      logic [CHAN_W-1:0]    red;
      logic [CHAN_W-1:0]    green;
      logic [CHAN_W-1:0]    blue;
      logic [OUT_POS_W-1:0] row;
      logic [OUT_POS_W-1:0] col;
      logic                 last;
   } blurred_px_type;

   // two row banks: row-2 at [0, MAX_WIDTH), row-1 at [MAX_WIDTH, 2*MAX_WIDTH)
   pixel_type        row_mem [2*MAX_WIDTH];
   pixel_type        win [9];
   logic [DIM_W-1:0] width_reg;
   logic [DIM_W-1:0] height_reg;
   logic [DIM_W-1:0] in_row;
   logic [COL_W-1:0] in_col;
   logic [ROW_W-1:0] emit_row;
   logic [COL_W-1:0] emit_col;
   blurred_px_type   blurred_q [$];

   initial begin
      fail_count = 0;
      pending    = 0;
      foreach (row_mem[i]) row_mem[i] = '0;
   end

   function automatic int unsigned dim_used(input logic [DIM_W-1:0] v, input int unsigned lim);
      if (v == '0) return 1;
      if (v > lim) return lim;
      return v;
   endfunction

   function void restart_frame();
      in_row   = '0;
      in_col   = '0;
      emit_row = '0;
      emit_col = '0;
   endfunction

   function void note_failure(input string what, input int unsigned exp_v,
                              input int unsigned got_v);
      fail_count++;
      $error("%s: expected %0d, got %0d", what, exp_v, got_v);
   endfunction

   // Advance the frame model by one accepted req beat; queue the blurred pixel it releases.
   function void blur_beat(input logic act, input pixel_type px);
      int unsigned    w, h, ir, col, r, c, sr, sg, sb, cnt;
      int             dr, dc;
      pixel_type      in_px, above2, above1, p;
      logic           started;
      blurred_px_type res;
      w  = dim_used(width_reg, MAX_WIDTH);
      h  = dim_used(height_reg, MAX_HEIGHT);
      ir = in_row;
      // drain while the frame still fills: no effect at all
      if (act == ACT_DRAIN && ir < h) return;
      in_px = (act == ACT_PIXEL && ir < h) ? px : '0;
      col = in_col;
      if (col >= w) col = 0;
      above2 = row_mem[col];
      above1 = row_mem[MAX_WIDTH + col];
      for (dr = 0; dr < 3; dr++) begin
         win[dr*3]     = win[dr*3 + 1];
         win[dr*3 + 1] = win[dr*3 + 2];
      end
      win[2] = above2;
      win[5] = above1;
      win[8] = in_px;
      row_mem[col]             = above1;
      row_mem[MAX_WIDTH + col] = in_px;
      started = (ir >= 2) || (ir == 1 && col >= 1);
      if (col + 1 >= w) begin
         in_col = '0;
         in_row = DIM_W'(ir + 1);
      end else begin
         in_col = COL_W'(col + 1);
      end
      if (!started) return;

      r  = emit_row;
      c  = emit_col;
      sr = 0;
      sg = 0;
      sb = 0;
      cnt = 0;
      for (dr = -1; dr <= 1; dr++) begin
         if (dr < 0 && r == 0) continue;
         if (dr > 0 && r + 1 >= h) continue;
         for (dc = -1; dc <= 1; dc++) begin
            if (dc < 0 && c == 0) continue;
            if (dc > 0 && c + 1 >= w) continue;
            p = win[(dr + 1)*3 + dc + 1];
            sr += p.red;
            sg += p.green;
            sb += p.blue;
            cnt++;
         end
      end
      if (cnt == 0) cnt = 1;
      res.red   = CHAN_W'((2*sr + cnt) / (2*cnt));
      res.green = CHAN_W'((2*sg + cnt) / (2*cnt));
      res.blue  = CHAN_W'((2*sb + cnt) / (2*cnt));
      res.row   = OUT_POS_W'(r);
      res.col   = OUT_POS_W'(c);
      res.last  = (r + 1 >= h) && (c + 1 >= w);
      blurred_q.push_back(res);
      if (res.last) begin
         restart_frame();
      end else if (c + 1 >= w) begin
         emit_col = '0;
         emit_row = ROW_W'(r + 1);
      end else begin
         emit_col = COL_W'(c + 1);
      end
   endfunction

   always @(posedge clock) begin
      blurred_px_type exp_px;
      if (reset) begin
         width_reg  = WIDTH_RESET;
         height_reg = HEIGHT_RESET;
         restart_frame();
         foreach (win[i]) win[i] = '0;
         blurred_q.delete();
      end else begin
         // compare first: a result never leaves in the cycle its input arrives
         if (rsp.valid && rsp.ready) begin
            if (blurred_q.size() == 0) begin
               note_failure("rsp beat with nothing expected, out_col", 0, rsp.out_col);
            end else begin
               exp_px = blurred_q.pop_front();
               if (rsp.red_out != exp_px.red)
                  note_failure("red_out", exp_px.red, rsp.red_out);
               if (rsp.green_out != exp_px.green)
                  note_failure("green_out", exp_px.green, rsp.green_out);
               if (rsp.blue_out != exp_px.blue)
                  note_failure("blue_out", exp_px.blue, rsp.blue_out);
               if (rsp.out_row != exp_px.row)
                  note_failure("out_row", exp_px.row, rsp.out_row);
               if (rsp.out_col != exp_px.col)
                  note_failure("out_col", exp_px.col, rsp.out_col);
               if (rsp.frame_last != exp_px.last)
                  note_failure("frame_last", exp_px.last, rsp.frame_last);
            end
         end
         if (csr.valid && csr.ready) begin
            if (csr.index == REG_FRAME_WIDTH) begin
               width_reg = csr.wdata;
               restart_frame();
            end else if (csr.index == REG_FRAME_HEIGHT) begin
               height_reg = csr.wdata;
               restart_frame();
            end
         end
         if (req.valid && req.ready)
            blur_beat(req.action, {req.red_in, req.green_in, req.blue_in});
      end
      pending = blurred_q.size();
   end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for the 3x3 RGB box blur: clock, reset, stimulus and verdict.
module tb_top;
   import bb3_pkg::*;
   import bb3_tb_pkg::*;

   localparam int HALF_PERIOD   = 10;
   localparam int RESET_CYCLES  = 11;
   // leave margin past the time that a beat with a result needs
   localparam int SETTLE_CYCLES = 16;
   localparam int RANDOM_ITEMS  = 750;
   // first index past the defined registers; writes there must change nothing
   localparam logic [IDX_W-1:0] REG_SPARE = REG_FRAME_HEIGHT + 1'b1;

   typedef enum logic [1:0] {
      STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_LONG
   } stall_mode_type;
   typedef enum logic [1:0] {DATA_RANDOM, DATA_EXTREME, DATA_STRIPES} pixel_mix_type;

   logic             clock;
   logic             reset;
   int               fail_count;
   int               pending;
   logic [DIM_W-1:0] width_set;
   logic [DIM_W-1:0] height_set;
   int               burst_left = 0;
   bit               bursty = 1'b0;
   int               random_items = 0;
   stall_mode_type   stall_mode = STALL_NONE;
   int unsigned      stall_tick = 0;
   int               stall_hold = 0;
   logic             stall_level = 1'b0;

   bb3_req_if req_ch ();
   bb3_rsp_if rsp_ch ();
   bb3_csr_if csr_ch ();

   box_blur_3x3_rgb uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_ch),
      .rsp_bus (rsp_ch),
      .csr_bus (csr_ch)
   );

   bb3_blur_checker blur_chk (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .rsp        (rsp_ch),
      .csr        (csr_ch),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial clock = 1'b0;
   always #HALF_PERIOD clock = ~clock;

   // Hard stop: the slowest correct run finishes well inside this.
   initial begin
      #20_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // Receiver back-pressure: switch now and then to a stall pattern picked at random,
   // from never stalling through random and periodic to long stall runs.
   always @(negedge clock) begin
      if (stall_tick % 300 == 0) stall_mode = stall_mode_type'($urandom_range(0, 3));
      stall_tick++;
      case (stall_mode)
         STALL_NONE:     rsp_ch.ready = 1'b1;
         STALL_RANDOM:   rsp_ch.ready = ($urandom_range(0, 3) != 0);
         STALL_PERIODIC: rsp_ch.ready = (stall_tick % 7 < 3);
         default: begin
            // hold each level for a random run of cycles, then flip it
            if (stall_hold == 0) begin
               stall_hold  = $urandom_range(1, 30);
               stall_level = ~stall_level;
            end
            stall_hold--;
            rsp_ch.ready = stall_level;
         end
      endcase
   end

   // Size the block really uses: zero runs as one, anything past the maximum as the maximum.
   function automatic int unsigned dim_used(input logic [DIM_W-1:0] v, input int unsigned lim);
      if (v == '0) return 1;
      if (v > lim) return lim;
      return v;
   endfunction

   function automatic pixel_type make_pixel(input pixel_mix_type mix, input int k);
      pixel_type px;
      case (mix)
         DATA_EXTREME: begin
            px.red   = $urandom_range(0, 1) ? '1 : '0;
            px.green = $urandom_range(0, 1) ? '1 : '0;
            px.blue  = $urandom_range(0, 1) ? '1 : '0;
         end
         DATA_STRIPES: begin
            // saturated red, dark green, alternating blue: sums land on rounding halves
            px.red   = '1;
            px.green = '0;
            px.blue  = (k % 2 != 0) ? '1 : '0;
         end
         default: px = PIX_W'($urandom());
      endcase
      return px;
   endfunction

   // Write one register while the block is idle; track the sizes for the frame loop.
   task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DIM_W-1:0] value);
      @(negedge clock);
      csr_ch.valid = 1'b1;
      csr_ch.index = idx;
      csr_ch.wdata = value;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid = 1'b0;
      if (idx == REG_FRAME_WIDTH) width_set = value;
      else if (idx == REG_FRAME_HEIGHT) height_set = value;
   endtask

   // Send one req beat; open a gap before each new burst when bursty.
   task automatic send_beat(input logic act, input pixel_type px);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = bursty ? $urandom_range(1, 6) : 0;
         if (gap > 0) begin
            @(negedge clock);
            req_ch.valid = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_ch.valid    = 1'b1;
      req_ch.action   = act;
      req_ch.red_in   = px.red;
      req_ch.green_in = px.green;
      req_ch.blue_in  = px.blue;
      // hold the beat until the block takes it
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Drop valid and wait until every blurred pixel is out and the pipeline is quiet.
   task automatic settle();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Feed one frame: w*h pixels with stray drains while it fills (those are
   // dropped), then w+1 trailing beats that push out the rest. The first
   // trailing beat is always a pixel, which must act as a drain. A nonzero
   // stop_at abandons the frame after that many counted beats.
   task automatic run_frame(input pixel_mix_type mix, input int stop_at, output int sent);
      int unsigned w, h, fill, total;
      int          k;
      w     = dim_used(width_set, MAX_WIDTH);
      h     = dim_used(height_set, MAX_HEIGHT);
      fill  = w * h;
      total = fill + w + 1;
      sent  = 0;
      for (k = 0; k < total; k++) begin
         if (stop_at != 0 && sent == stop_at) break;
         if (k < fill) begin
            if ($urandom_range(0, 11) == 0) send_beat(ACT_DRAIN, make_pixel(DATA_RANDOM, k));
            send_beat(ACT_PIXEL, make_pixel(mix, k));
         end else if (k == fill) begin
            send_beat(ACT_PIXEL, make_pixel(mix, k));
         end else begin
            send_beat($urandom_range(0, 1) ? ACT_DRAIN : ACT_PIXEL, make_pixel(DATA_RANDOM, k));
         end
         sent++;
      end
   endtask

   initial begin
      int          n;
      int          frames;
      int          cut;
      int unsigned w_pick;
      int unsigned h_pick;

      // known values on every input from time zero
      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.action   = ACT_PIXEL;
      req_ch.red_in   = '0;
      req_ch.green_in = '0;
      req_ch.blue_in  = '0;
      csr_ch.valid    = 1'b0;
      csr_ch.index    = REG_FRAME_WIDTH;
      csr_ch.wdata    = '0;
      rsp_ch.ready    = 1'b0;
      width_set       = WIDTH_RESET;
      height_set      = HEIGHT_RESET;
      repeat (RESET_CYCLES) @(negedge clock);
      reset = 1'b0;

      // Directed: 3x3 stripe frame, led by a drain that must be dropped.
      write_reg(REG_FRAME_WIDTH, 3);
      write_reg(REG_FRAME_HEIGHT, 3);
      send_beat(ACT_DRAIN, '1);
      run_frame(DATA_STRIPES, 0, n);
      settle();

      // Directed: zero sizes run as a 1x1 frame; the spare index changes nothing.
      write_reg(REG_FRAME_WIDTH, '0);
      write_reg(REG_FRAME_HEIGHT, '0);
      write_reg(REG_SPARE, '1);
      run_frame(DATA_EXTREME, 0, n);

      // Random phases: mostly small frames, a few wide ones. Some phases write
      // only one register, some frames are cut short and restarted by the next
      // write, and some phases run without sender gaps.
      while (random_items < RANDOM_ITEMS) begin
         settle();
         bursty = ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 9))
            0:       w_pick = 0;
            8, 9:    w_pick = $urandom_range(9, 40);
            default: w_pick = $urandom_range(1, 8);
         endcase
         h_pick = (w_pick > 8) ? $urandom_range(1, 6) : $urandom_range(0, 12);
         case ($urandom_range(0, 3))
            0:       write_reg(REG_FRAME_WIDTH, w_pick);
            1:       write_reg(REG_FRAME_HEIGHT, h_pick);
            default: begin
               write_reg(REG_FRAME_WIDTH, w_pick);
               write_reg(REG_FRAME_HEIGHT, h_pick);
            end
         endcase
         frames = $urandom_range(1, 3);
         repeat (frames) begin
            cut = ($urandom_range(0, 5) == 0) ?
                  $urandom_range(1, dim_used(width_set, MAX_WIDTH) *
                                    dim_used(height_set, MAX_HEIGHT)) : 0;
            run_frame(pixel_mix_type'($urandom_range(0, 2)), cut, n);
            random_items += n;
            // an abandoned frame needs a register write before the next one
            if (cut != 0) break;
         end
      end

      // drain everything still in flight, then give the verdict
      settle();
      if (fail_count == 0 && pending == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

### sim.f
src/bb3_pkg.sv
src/bb3_channels.sv
src/bb3_datapath.sv
src/bb3_control.sv
src/box_blur_3x3_rgb.sv
src/bb3_checker.sv
tb/bb3_tb_pkg.sv
tb/bb3_blur_checker.sv
tb/tb_top.sv
